### rtl/core/hilbert_tile_list_generator_defines.svh
// ----------------------------------------------------------------------------
// hilbert_tile_list_generator_defines
// Assertion macros for the Hilbert tile list generator. They expand to nothing
// in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HILBERT_TILE_LIST_GENERATOR_DEFINES_SVH
`define HILBERT_TILE_LIST_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset.
`define HLTG_ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("hltg assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define HLTG_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("hltg assertion failed");
`else
`define HLTG_ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define HLTG_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)
`endif

`endif

### rtl/core/hltg_pkg.sv
// ----------------------------------------------------------------------------
// hltg_pkg
// Shared widths, command constants and types of the Hilbert tile list
// generator.
// ----------------------------------------------------------------------------
package hltg_pkg;

    localparam int MAX_STREAMS_DEF   = 4;
    localparam int MAX_SIDE_LOG2_DEF = 8;

    localparam int HIDX_W     = 16;
    localparam int TILES_W    = 9;
    localparam int SHIFT_W    = 3;
    localparam int SCNT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WORD_W     = 32;
    localparam int SEL_W      = 2;
    localparam int POS_W      = 8;

    localparam logic [WORD_W-1:0] CMD_TILE_POS   = 32'hB800_0000;
    localparam logic [WORD_W-1:0] CMD_BLOCK_ADDR = 32'hE000_0002;
    localparam logic [WORD_W-1:0] CMD_ADDR_MASK  = ~32'hE000_0003;
    localparam logic [WORD_W-1:0] CMD_TILE_END   = 32'hB000_0000;
    localparam logic [WORD_W-1:0] CMD_TERMINATE  = 32'hBC00_0000;
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_LOG2  = $clog2(BLOCK_BYTES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILES_WIDE   = 3'd0,
        CFG_TILES_HIGH   = 3'd1,
        CFG_BLOCK_SHIFTX = 3'd2,
        CFG_BLOCK_SHIFTY = 3'd3,
        CFG_BLOCKS_ROW   = 3'd4,
        CFG_LIST_BASE    = 3'd5,
        CFG_STREAM_COUNT = 3'd6
    } t_cfg_idx;

    // List block addressing settings
    typedef struct packed {
        logic [SHIFT_W-1:0] shift_x;
        logic [SHIFT_W-1:0] shift_y;
        logic [TILES_W-1:0] blocks_per_row;
        logic [WORD_W-1:0]  base;
    } t_addr_cfg;

endpackage

### rtl/core/hltg_curve.sv
// ----------------------------------------------------------------------------
// hltg_curve
// Maps a Hilbert index to tile x,y and flags whether the tile lies inside
// the tiled area.
// ----------------------------------------------------------------------------
module hltg_curve
    import hltg_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
    input  logic [HIDX_W-1:0]        i_index,
    input  logic [TILES_W-1:0]       i_tiles_wide,
    input  logic [TILES_W-1:0]       i_tiles_high,
    output logic [MAX_SIDE_LOG2-1:0] o_x,
    output logic [MAX_SIDE_LOG2-1:0] o_y,
    output logic                     o_inside
);

    localparam int CW   = MAX_SIDE_LOG2;
    localparam int DW   = $clog2(MAX_SIDE_LOG2 + 1);
    localparam int IW   = (2 * CW > HIDX_W) ? 2 * CW : HIDX_W;
    localparam int CMPW = (CW > TILES_W) ? CW : TILES_W;

    logic [TILES_W-1:0] larger;
    logic [DW-1:0]      dim;
    logic [IW-1:0]      idx_pad;
    logic [CW-1:0]      cx;
    logic [CW-1:0]      cy;
    logic [CW-1:0]      tmp;
    logic [CW-1:0]      msk;
    logic               rx;
    logic               ry;

    assign larger  = (i_tiles_wide > i_tiles_high) ? i_tiles_wide : i_tiles_high;
    assign idx_pad = IW'(i_index);

    // Smallest curve side at or above the larger dimension, saturated
    always_comb begin
        dim = '0;
        for (int i = 0; i < CW; i++) begin
            if ((32'd1 << i) < 32'(larger)) begin
                dim = DW'(i + 1);
            end
        end
    end

    // Two index bits per level; each level is a conditional flip and swap
    always_comb begin
        cx  = '0;
        cy  = '0;
        tmp = '0;
        for (int lvl = 0; lvl < CW; lvl++) begin
            rx  = idx_pad[2*lvl+1];
            ry  = idx_pad[2*lvl] ^ rx;
            msk = CW'((1 << lvl) - 1);
            if (DW'(lvl) < dim) begin
                if (!ry) begin
                    if (rx) begin
                        cx = cx ^ msk;
                        cy = cy ^ msk;
                    end
                    tmp = cx;
                    cx  = cy;
                    cy  = tmp;
                end
                cx[lvl] = rx;
                cy[lvl] = ry;
            end
        end
    end

    assign o_x      = cx;
    assign o_y      = cy;
    assign o_inside = (CMPW'(cx) < CMPW'(i_tiles_wide)) &&
                      (CMPW'(cy) < CMPW'(i_tiles_high));

endmodule

### rtl/core/hltg_words.sv
// ----------------------------------------------------------------------------
// hltg_words
// Forms the three command words of a tile: position, list block address
// and tile end.
// ----------------------------------------------------------------------------
module hltg_words
    import hltg_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
    input  logic [MAX_SIDE_LOG2-1:0] i_x,
    input  logic [MAX_SIDE_LOG2-1:0] i_y,
    input  t_addr_cfg                i_cfg,
    output logic [WORD_W-1:0]        o_word_a,
    output logic [WORD_W-1:0]        o_word_b,
    output logic [WORD_W-1:0]        o_word_c
);

    localparam int CW   = MAX_SIDE_LOG2;
    localparam int PW   = CW + TILES_W;
    localparam int SW   = PW + 1;

    logic [CW-1:0]     xs;
    logic [CW-1:0]     ys;
    logic [PW-1:0]     prod;
    logic [SW-1:0]     blk;
    logic [WORD_W-1:0] offs;
    logic [WORD_W-1:0] addr;

    assign xs   = i_x >> i_cfg.shift_x;
    assign ys   = i_y >> i_cfg.shift_y;
    assign prod = PW'(ys) * PW'(i_cfg.blocks_per_row);
    assign blk  = SW'(prod) + SW'(xs);
    // Block size is a power of two: scale by shift, wrap to the word
    assign offs = WORD_W'({blk, {BLOCK_LOG2{1'b0}}});
    assign addr = i_cfg.base + offs;

    assign o_word_a = CMD_TILE_POS | {16'd0, POS_W'(i_y), POS_W'(i_x)};
    assign o_word_b = CMD_BLOCK_ADDR | ((addr >> 3) & CMD_ADDR_MASK);
    assign o_word_c = CMD_TILE_END;

endmodule

### rtl/core/hilbert_tile_list_generator.sv
// ----------------------------------------------------------------------------
// hilbert_tile_list_generator
// Turns Hilbert-ordered tile requests into per-stream tile list words and
// emits one terminator per stream on a finish request.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..tready | tdata: hilbert_index
//            |           |                            | tuser: req_type
//  m_axis    | out       | o_m_axis_tvalid/i_..tready | tdata: x,y,word_a,b,c
//            |           |                            | tuser: stream_sel,is_term
//  cfg       | in        | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  A tile request passes through three registers in turn (input, curve,
//  result); one word per cycle is sustained while the result register is
//  not stalled and no finish request holds the curve stage.
//  A finish request holds the curve stage until one terminator per active
//  stream has passed into the result register.
//  Tiles outside the area are dropped at the curve stage.
//  A stalled result register stalls the whole pipe; the input side still
//  fills empty stages. Synchronous active-low reset clears control and
//  configuration; no clearing pass is needed.
//
`include "hilbert_tile_list_generator_defines.svh"

module hilbert_tile_list_generator
    import hltg_pkg::*;
#(
    parameter int MAX_STREAMS   = MAX_STREAMS_DEF,
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [HIDX_W-1:0]     i_s_axis_tdata,   // [15:0] hilbert_index
    input  logic                  i_s_axis_tuser,   // [0] req_type
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [111:0]          o_m_axis_tdata,   // [7:0] tile_x, [15:8] tile_y,
                                                    // [47:16] word_a, [79:48] word_b,
                                                    // [111:80] word_c
    output logic [2:0]            o_m_axis_tuser,   // [1:0] stream_sel, [2] is_terminator
    output logic                  o_m_axis_tlast,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = MAX_SIDE_LOG2;

    // Configuration
    logic [TILES_W-1:0] r_tiles_wide;
    logic [TILES_W-1:0] r_tiles_high;
    logic [SCNT_W-1:0]  r_stream_count;
    t_addr_cfg          r_addr_cfg;

    // Input stage
    logic               r_s1_valid;
    logic               r_s1_finish;
    logic [HIDX_W-1:0]  r_s1_index;

    // Curve stage
    logic               r_s2_valid;
    logic               r_s2_finish;
    logic [CW-1:0]      r_s2_x;
    logic [CW-1:0]      r_s2_y;

    // Round-robin and terminator sequencing
    logic [SEL_W-1:0]   r_next_stream;
    logic [SEL_W-1:0]   n_next_stream;
    logic [SCNT_W-1:0]  r_term_idx;
    logic [SCNT_W-1:0]  n_term_idx;

    // Result register
    logic               r_out_valid;
    logic [111:0]       r_out_data;
    logic [2:0]         r_out_user;
    logic               r_out_last;

    logic [CW-1:0]      curve_x;
    logic [CW-1:0]      curve_y;
    logic               curve_inside;
    logic [WORD_W-1:0]  word_a;
    logic [WORD_W-1:0]  word_b;
    logic [WORD_W-1:0]  word_c;

    logic [SCNT_W-1:0]  cnt;
    logic [SEL_W-1:0]   sel;
    logic [SCNT_W-1:0]  sel_inc;
    logic [SCNT_W-1:0]  term_inc;
    logic               term_last;
    logic               out_free;
    logic               s2_emit;
    logic               s2_done;
    logic               s2_free;
    logic               s1_move;
    logic               in_take;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_wide              <= TILES_W'(1);
            r_tiles_high              <= TILES_W'(1);
            r_stream_count            <= SCNT_W'(1);
            r_addr_cfg.shift_x        <= '0;
            r_addr_cfg.shift_y        <= '0;
            r_addr_cfg.blocks_per_row <= TILES_W'(1);
            r_addr_cfg.base           <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TILES_WIDE:   r_tiles_wide              <= i_cfg_data[TILES_W-1:0];
                CFG_TILES_HIGH:   r_tiles_high              <= i_cfg_data[TILES_W-1:0];
                CFG_BLOCK_SHIFTX: r_addr_cfg.shift_x        <= i_cfg_data[SHIFT_W-1:0];
                CFG_BLOCK_SHIFTY: r_addr_cfg.shift_y        <= i_cfg_data[SHIFT_W-1:0];
                CFG_BLOCKS_ROW:   r_addr_cfg.blocks_per_row <= i_cfg_data[TILES_W-1:0];
                CFG_LIST_BASE:    r_addr_cfg.base           <= i_cfg_data[WORD_W-1:0];
                CFG_STREAM_COUNT: r_stream_count            <= i_cfg_data[SCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Active streams: zero acts as one, clamp to the build maximum
    always_comb begin
        cnt = r_stream_count;
        if (r_stream_count == '0) begin
            cnt = SCNT_W'(1);
        end else if (int'(r_stream_count) > MAX_STREAMS) begin
            cnt = SCNT_W'(MAX_STREAMS);
        end
    end

    // Pipe control: the result register frees the stages behind it
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign s2_emit   = r_s2_valid && out_free;
    assign term_inc  = r_term_idx + SCNT_W'(1);
    assign term_last = (term_inc == cnt);
    assign s2_done   = s2_emit && (!r_s2_finish || term_last);
    assign s2_free   = !r_s2_valid || s2_done;
    assign s1_move   = r_s1_valid && s2_free;
    assign o_s_axis_tready = !r_s1_valid || s2_free;
    assign in_take   = i_s_axis_tvalid && o_s_axis_tready;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_finish <= i_s_axis_tuser;
            r_s1_index  <= i_s_axis_tdata;
        end
    end

    hltg_curve #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_curve (
        .i_index      (r_s1_index),
        .i_tiles_wide (r_tiles_wide),
        .i_tiles_high (r_tiles_high),
        .o_x          (curve_x),
        .o_y          (curve_y),
        .o_inside     (curve_inside)
    );

    // Curve stage: drop tiles outside the area here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move) begin
            r_s2_valid <= r_s1_finish || curve_inside;
        end else if (s2_done) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_finish <= r_s1_finish;
            r_s2_x      <= curve_x;
            r_s2_y      <= curve_y;
        end
    end

    hltg_words #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_words (
        .i_x      (r_s2_x),
        .i_y      (r_s2_y),
        .i_cfg    (r_addr_cfg),
        .o_word_a (word_a),
        .o_word_b (word_b),
        .o_word_c (word_c)
    );

    // Round-robin pick; a pointer left past a lowered count falls back to 0
    assign sel     = ({1'b0, r_next_stream} < cnt) ? r_next_stream : '0;
    assign sel_inc = SCNT_W'(sel) + SCNT_W'(1);

    always_comb begin
        n_next_stream = r_next_stream;
        n_term_idx    = r_term_idx;
        if (s2_emit) begin
            if (r_s2_finish) begin
                n_term_idx = term_last ? '0 : term_inc;
                if (term_last) begin
                    n_next_stream = '0;
                end
            end else begin
                n_next_stream = (sel_inc == cnt) ? '0 : sel_inc[SEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_stream <= '0;
            r_term_idx    <= '0;
        end else begin
            r_next_stream <= n_next_stream;
            r_term_idx    <= n_term_idx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit) begin
            if (r_s2_finish) begin
                r_out_data <= {64'd0, CMD_TERMINATE, 16'd0};
                r_out_user <= {1'b1, r_term_idx[SEL_W-1:0]};
                r_out_last <= term_last;
            end else begin
                r_out_data <= {word_c, word_b, word_a, POS_W'(r_s2_y), POS_W'(r_s2_x)};
                r_out_user <= {1'b0, sel};
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    // A tile word always closes its request
    `HLTG_ASSERT_HOLDS(a_tile_is_last, i_clk, i_rst_n, !r_out_valid || r_out_user[2] || r_out_last)
    // A completed finish leaves the round-robin pointer at stream 0
    `HLTG_ASSERT_NEXT(a_finish_clears_rr, i_clk, i_rst_n, s2_done && r_s2_finish, r_next_stream == '0)
    // Hold the curve stage while the result register is stalled
    `HLTG_ASSERT_HOLDS(a_no_emit_on_stall, i_clk, i_rst_n, !(r_out_valid && !i_m_axis_tready && s2_emit))
    // An accepted word lands in the input stage
    `HLTG_ASSERT_NEXT(a_take_fills_s1, i_clk, i_rst_n, in_take, r_s1_valid)

endmodule
